FILE: rtl/sjfq_pkg.sv
// shared types and constants for the shortest-job-first queue
// no dependencies; imported by sjfq_ctrl, sjfq_dp and the top level
package sjfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_START     = 3'd1,
        EV_QUEUED    = 3'd2,
        EV_DROPPED   = 3'd3,
        EV_DONE_NEXT = 3'd4,
        EV_DONE_IDLE = 3'd5
    } evt_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SCAN_END,
        ST_SHIFT_SET,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic commit_simple;
        logic scan_init;
        logic scan_rd;
        logic shift_init;
        logic shift_rd;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic rd_last;
        logic shift_more;
    } status_t;

endpackage

FILE: rtl/sjfq_ram.sv
// generic single-write, single-read memory with registered read data
// depends on nothing
module sjfq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sjfq_ctrl.sv
// controller state machine: sequences execute, minimum scan, queue shift and commit
// depends on sjfq_pkg
module sjfq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  sjfq_pkg::status_t status,
    output sjfq_pkg::cmd_t    cmd
);

    import sjfq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.need_scan)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else if (out_free)
                begin
                    cmd.commit_simple = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_SHIFT_SET;
            end
            ST_SHIFT_SET:
            begin
                cmd.shift_init = 1'b1;
                state_next     = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (status.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit_simple || cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

FILE: rtl/sjfq_dp.sv
// datapath: server state, time counter, waiting-job memory, minimum search and result register
// depends on sjfq_pkg and sjfq_ram
module sjfq_dp #(
    parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = sjfq_pkg::TIME_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sjfq_pkg::cmd_t    cmd,
    output sjfq_pkg::status_t status,
    input  logic              kind,
    input  logic [15:0]       job_tag,
    input  logic [15:0]       job_length,
    output logic [2:0]        event_res,
    output logic [15:0]       done_tag,
    output logic [31:0]       response_time,
    output logic [15:0]       started_tag,
    output logic [31:0]       queueing_time,
    output logic [4:0]        queue_length,
    output logic              busy_res
);

    import sjfq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = TIME_WIDTH;
    localparam int MW = 32 + TW;

    // request held for execution
    logic          kind_reg;
    logic [15:0]   tag_reg;
    logic [15:0]   svc_reg;

    // server and queue state
    logic [TW-1:0] time_reg,   time_next;
    logic          busy_reg,   busy_next;
    logic [15:0]   remain_reg, remain_next;
    logic [15:0]   act_tag_reg, act_tag_next;
    logic [TW-1:0] act_arr_reg, act_arr_next;
    logic [CW-1:0] count_reg,  count_next;

    // scan and shift
    logic [CW-1:0] ptr_reg,    ptr_next;
    logic [AW-1:0] rd_idx_reg;
    logic          scan_cmp_reg;
    logic          shift_wr_reg;
    logic [AW-1:0] best_idx_reg;
    logic [15:0]   best_tag_reg;
    logic [15:0]   best_svc_reg;
    logic [TW-1:0] best_arr_reg;

    // result register
    evt_code_t     ev_reg,    ev_next;
    logic [15:0]   dtag_reg,  dtag_next;
    logic [31:0]   resp_reg,  resp_next;
    logic [15:0]   stag_reg,  stag_next;
    logic [31:0]   qtime_reg, qtime_next;
    logic [4:0]    qlen_reg;
    logic          busyo_reg;

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic [MW-1:0] rd_data;
    logic [15:0]   rd_tag;
    logic [15:0]   rd_svc;
    logic [TW-1:0] rd_arr;
    logic          queue_wr;

    logic [TW-1:0]    time_inc;
    logic [TW+31:0]   resp_ext;
    logic [TW+31:0]   qtime_ext;
    logic [CW+4:0]    count_ext;
    logic             completing;

    sjfq_ram #(
        .WIDTH (MW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_tag = rd_data[MW-1 -: 16];
    assign rd_svc = rd_data[TW+15 -: 16];
    assign rd_arr = rd_data[TW-1:0];

    assign time_inc   = time_reg + TW'(1);
    assign completing = busy_reg && (remain_reg[15:1] == 15'd0);

    assign status.need_scan  = kind_reg && completing && (count_reg != '0);
    assign status.rd_last    = (ptr_reg == count_reg - CW'(1));
    assign status.shift_more = (ptr_reg < count_reg);

    assign queue_wr = cmd.commit_simple && !kind_reg && busy_reg
                      && (count_reg < CW'(QUEUE_DEPTH));

    always_comb
    begin
        if (shift_wr_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - AW'(1);
            wr_data = rd_data;
        end
        else
        begin
            wr_en   = queue_wr;
            wr_addr = count_reg[AW-1:0];
            wr_data = {tag_reg, svc_reg, time_reg};
        end
    end

    always_comb
    begin
        time_next    = time_reg;
        busy_next    = busy_reg;
        remain_next  = remain_reg;
        act_tag_next = act_tag_reg;
        act_arr_next = act_arr_reg;
        count_next   = count_reg;
        ev_next      = EV_NONE;
        dtag_next    = 16'd0;
        resp_next    = 32'd0;
        stag_next    = 16'd0;
        qtime_next   = 32'd0;
        resp_ext     = {{32{1'b0}}, time_inc - act_arr_reg};
        qtime_ext    = {{32{1'b0}}, time_inc - best_arr_reg};
        if (cmd.commit_simple)
        begin
            if (!kind_reg)
            begin
                if (!busy_reg)
                begin
                    busy_next    = 1'b1;
                    act_tag_next = tag_reg;
                    act_arr_next = time_reg;
                    remain_next  = svc_reg;
                    ev_next      = EV_START;
                    stag_next    = tag_reg;
                end
                else if (count_reg < CW'(QUEUE_DEPTH))
                begin
                    count_next = count_reg + CW'(1);
                    ev_next    = EV_QUEUED;
                end
                else
                begin
                    ev_next = EV_DROPPED;
                end
            end
            else
            begin
                time_next = time_inc;
                if (completing)
                begin
                    busy_next   = 1'b0;
                    remain_next = 16'd0;
                    ev_next     = EV_DONE_IDLE;
                    dtag_next   = act_tag_reg;
                    resp_next   = resp_ext[31:0];
                end
                else if (busy_reg)
                begin
                    remain_next = remain_reg - 16'd1;
                end
            end
        end
        else if (cmd.finish)
        begin
            time_next    = time_inc;
            act_tag_next = best_tag_reg;
            act_arr_next = best_arr_reg;
            remain_next  = best_svc_reg;
            count_next   = count_reg - CW'(1);
            ev_next      = EV_DONE_NEXT;
            dtag_next    = act_tag_reg;
            resp_next    = resp_ext[31:0];
            stag_next    = best_tag_reg;
            qtime_next   = qtime_ext[31:0];
        end
        count_ext = {5'd0, count_next};
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.shift_init)
        begin
            ptr_next = CW'(best_idx_reg) + CW'(1);
        end
        else if (cmd.scan_rd || cmd.shift_rd)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            busy_reg     <= 1'b0;
            remain_reg   <= 16'd0;
            act_tag_reg  <= 16'd0;
            act_arr_reg  <= '0;
            count_reg    <= '0;
            ptr_reg      <= '0;
            scan_cmp_reg <= 1'b0;
            shift_wr_reg <= 1'b0;
        end
        else
        begin
            time_reg     <= time_next;
            busy_reg     <= busy_next;
            remain_reg   <= remain_next;
            act_tag_reg  <= act_tag_next;
            act_arr_reg  <= act_arr_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            scan_cmp_reg <= cmd.scan_rd;
            shift_wr_reg <= cmd.shift_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= ptr_reg[AW-1:0];
        if (cmd.take)
        begin
            kind_reg <= kind;
            tag_reg  <= job_tag;
            svc_reg  <= job_length;
        end
        // first entry seeds the minimum, strict compare keeps earliest on ties
        if (scan_cmp_reg && ((rd_idx_reg == '0) || (rd_svc < best_svc_reg)))
        begin
            best_idx_reg <= rd_idx_reg;
            best_tag_reg <= rd_tag;
            best_svc_reg <= rd_svc;
            best_arr_reg <= rd_arr;
        end
        if (cmd.commit_simple || cmd.finish)
        begin
            ev_reg    <= ev_next;
            dtag_reg  <= dtag_next;
            resp_reg  <= resp_next;
            stag_reg  <= stag_next;
            qtime_reg <= qtime_next;
            qlen_reg  <= count_ext[4:0];
            busyo_reg <= busy_next;
        end
    end

    assign event_res     = ev_reg;
    assign done_tag      = dtag_reg;
    assign response_time = resp_reg;
    assign started_tag   = stag_reg;
    assign queueing_time = qtime_reg;
    assign queue_length  = qlen_reg;
    assign busy_res      = busyo_reg;

endmodule

FILE: rtl/shortest_job_first_queue.sv
// top level of the shortest-job-first single-server scheduler
// depends on sjfq_pkg, sjfq_ctrl, sjfq_dp (which holds sjfq_ram)
//
// Each request is either a job arrival (kind 0) or one time tick (kind 1) and
// yields exactly one result. An arrival or a tick that finishes no job with a
// waiting successor loads the result register from ST_EXEC once the output
// register is free. A tick that finishes a job while jobs wait goes through
// ST_EXEC, ST_SCAN, ST_SCAN_END, ST_SHIFT_SET, ST_SHIFT and ST_FINISH, where
// it loads the result: the waiting jobs sit in a memory with one read port
// that is scanned one entry a cycle for the minimum service time and then
// shifted down by one place, entry by entry, behind the chosen job. One request is worked
// on at a time; a new request is taken while a finished result still waits in
// the output register, and its last step waits until that result is taken.
// Times are TIME_WIDTH-bit wrapping counters and reported times are their low
// 32 bits. queue_length shows the low 5 bits of the count.
module shortest_job_first_queue #(
    parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = sjfq_pkg::TIME_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        kind,
    input  logic [15:0] job_tag,
    input  logic [15:0] job_length,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  event_res,
    output logic [15:0] done_tag,
    output logic [31:0] response_time,
    output logic [15:0] started_tag,
    output logic [31:0] queueing_time,
    output logic [4:0]  queue_length,
    output logic        busy_res
);

    import sjfq_pkg::*;

    cmd_t    cmd;
    status_t status;

    sjfq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    sjfq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .job_tag       (job_tag),
        .job_length    (job_length),
        .event_res     (event_res),
        .done_tag      (done_tag),
        .response_time (response_time),
        .started_tag   (started_tag),
        .queueing_time (queueing_time),
        .queue_length  (queue_length),
        .busy_res      (busy_res)
    );

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.commit_simple, cmd.scan_init, cmd.finish}))
        else $error("controller issued conflicting commands");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> !item_ready)
        else $error("request port reopened while a request is in work");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.commit_simple || cmd.finish))
        else $error("result appeared without a commit");

    a_done_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_res == EV_DONE_NEXT || event_res == EV_START)) |-> busy_res)
        else $error("server idle after starting a job");

    a_done_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && event_res == EV_DONE_IDLE) |-> (!busy_res && queue_length == 5'd0))
        else $error("server went idle with jobs waiting");

endmodule
